>>> rtl/ffba_pkg.sv
// shared types, constants and request codes of the first-fit block allocator
// no dependencies; imported by ffba_ctrl, ffba_dp and first_fit_block_allocator_unit
`default_nettype none

package ffba_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int OFFSET_BITS   = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	// compare width for lengths against a 32-bit amount
	localparam int AMT_W         = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	localparam int IN_BYTES      = (2 + 32 + 32 + 7) / 8;
	localparam int OUT_BYTES     = (1 + 32 + 7) / 8;
	localparam int IN_W          = IN_BYTES * 8;
	localparam int OUT_W         = OUT_BYTES * 8;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;

	typedef logic [OFFSET_BITS-1:0] ofs_t;
	typedef logic [AMT_W-1:0]       amt_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef struct packed {
		logic used;
		ofs_t length;
		ofs_t start;
	} entry_t;

	typedef struct packed {
		logic load;    // capture a new request
		logic rd;      // read the table at the scan address
		logic wr_fit;  // write the shrunk fit entry
		logic wr_rem;  // write the remainder into the first empty entry
		logic fmt;     // rebuild the table from region size
		logic res_ld;  // load the result register
	} cmd_t;

	typedef struct packed {
		logic last_rd;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/ffba_ctrl.sv
// request sequencer of the first-fit block allocator: scan, write-back and result steps
// depends on ffba_pkg
`default_nettype none

module ffba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    in_op,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ffba_pkg::cmd_t     cmd,
	input  wire ffba_pkg::sts_t sts
);
	import ffba_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WFIT  = 3'd3;
	localparam logic [2:0] ST_WREM  = 3'd4;
	localparam logic [2:0] ST_FMT   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] op_q;
	logic       out_valid_q;
	logic       res_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign res_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_op)
						OP_ALLOC:  state_d = ST_SCAN;
						OP_FREE:   state_d = ST_SCAN;
						OP_FORMAT: state_d = ST_FMT;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read is evaluated in the datapath this cycle
				state_d = (op_q == OP_ALLOC) ? ST_WFIT : ST_DONE;
			end
			ST_WFIT: begin
				cmd.wr_fit = 1'b1;
				state_d    = ST_WREM;
			end
			ST_WREM: begin
				cmd.wr_rem = 1'b1;
				state_d    = ST_DONE;
			end
			ST_FMT: begin
				cmd.fmt = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_free) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ALLOC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= in_op;
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ffba_dp.sv
// datapath of the first-fit block allocator: block table memory, scan evaluation,
// write-back port, region size register and result register; depends on ffba_pkg
`default_nettype none

module ffba_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ffba_pkg::cmd_t cmd,
	output ffba_pkg::sts_t      sts,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	input  wire logic [1:0]     in_op,
	input  wire logic [31:0]    in_amount,
	input  wire logic [31:0]    in_free_start,
	output logic                res_granted,
	output logic [31:0]         res_offset
);
	import ffba_pkg::*;

	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic [31:0] region_q;
	logic [1:0]  op_q;
	amt_t        amt_q;
	logic [31:0] fstart_q;

	idx_t   rd_idx_q;
	logic   rd_s1;
	idx_t   ev_idx_s1;
	entry_t rd_data_s1;
	logic   rd_vld_s1;
	entry_t ev;

	logic   fit_q;
	idx_t   fit_idx_q;
	ofs_t   base_q;
	ofs_t   oldlen_q;
	logic   emp_q;
	idx_t   emp_idx_q;

	logic   fits;
	logic   empty_cand;
	logic   we;
	idx_t   waddr;
	entry_t wdata;

	assign sts.last_rd = (rd_idx_q == idx_t'(TABLE_ENTRIES - 1));

	// an entry never written since reset or format reads as all zero
	assign ev = rd_vld_s1 ? rd_data_s1 : '0;

	assign fits = !ev.used && (amt_t'(ev.length) >= amt_q);
	// the fit entry itself counts as empty once shrunk to a zero amount
	assign empty_cand = (!fit_q && fits) ? (amt_q == '0) : (ev.length == '0);

	always_comb begin
		we    = 1'b0;
		waddr = ev_idx_s1;
		wdata = ev;
		if (rd_s1 && op_q == OP_FREE) begin
			if (rd_vld_s1 && ev.used && ev.start == ofs_t'(fstart_q)) begin
				we         = 1'b1;
				wdata.used = 1'b0;
			end
		end else if (cmd.wr_fit) begin
			we    = fit_q;
			waddr = fit_idx_q;
			wdata = '{used: 1'b1, length: ofs_t'(amt_q), start: base_q};
		end else if (cmd.wr_rem) begin
			we    = fit_q && emp_q;
			waddr = emp_idx_q;
			wdata = '{used: 1'b0, length: ofs_t'(oldlen_q - ofs_t'(amt_q)),
			          start: ofs_t'(base_q + ofs_t'(amt_q))};
		end else if (cmd.fmt) begin
			we    = 1'b1;
			waddr = '0;
			wdata = '{used: 1'b0, length: ofs_t'(region_q), start: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			region_q  <= '0;
			rd_idx_q  <= '0;
			rd_s1     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			fit_q     <= 1'b0;
			emp_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				region_q <= cfg_wdata;
			end
			if (cmd.fmt) begin
				// only entry 0 holds data after a format
				vld_q <= {{(TABLE_ENTRIES-1){1'b0}}, 1'b1};
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_s1 <= cmd.rd;
			if (cmd.rd) begin
				rd_vld_s1 <= vld_q[rd_idx_q];
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
				fit_q    <= 1'b0;
				emp_q    <= 1'b0;
			end else begin
				if (cmd.rd && !sts.last_rd) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (rd_s1 && op_q == OP_ALLOC) begin
					if (!fit_q && fits) begin
						fit_q <= 1'b1;
					end
					if (!emp_q && empty_cand) begin
						emp_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			amt_q    <= amt_t'(in_amount);
			fstart_q <= in_free_start;
		end
		if (cmd.rd) begin
			ev_idx_s1 <= rd_idx_q;
		end
		if (rd_s1 && op_q == OP_ALLOC) begin
			if (!fit_q && fits) begin
				fit_idx_q <= ev_idx_s1;
				base_q    <= ev.start;
				oldlen_q  <= ev.length;
			end
			if (!emp_q && empty_cand) begin
				emp_idx_q <= ev_idx_s1;
			end
		end
		if (cmd.res_ld) begin
			case (op_q)
				OP_ALLOC: begin
					res_granted <= fit_q;
					res_offset  <= fit_q ? 32'(base_q) : 32'd0;
				end
				OP_FREE: begin
					res_granted <= 1'b1;
					res_offset  <= 32'd0;
				end
				OP_FORMAT: begin
					res_granted <= 1'b1;
					res_offset  <= 32'd0;
				end
				default: begin
					res_granted <= 1'b0;
					res_offset  <= 32'd0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/first_fit_block_allocator_unit.sv
// allocate and free scan the whole table, one entry per cycle through the single read port;
// format and unused code skip the scan. the next request is accepted as soon as the result
// is loaded into the output register and can be taken.
// a finished result waits in the output register while the next request is accepted.
// reset (arst_n low) clears region size, empties the table and drops any pending result.
// top level of the first-fit block allocator; depends on ffba_pkg, ffba_ctrl and ffba_dp
`default_nettype none

module first_fit_block_allocator_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// operation [1:0], amount [33:2], free_start [65:34], zero fill above
	input  wire logic [ffba_pkg::IN_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// granted [0], block_offset [32:1], zero fill above
	output logic [ffba_pkg::OUT_W-1:0]      m_tdata,
	input  wire logic                       cfg_we,
	input  wire logic [31:0]                cfg_wdata
);
	import ffba_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic        res_granted;
	logic [31:0] res_offset;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tdata[1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ffba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_op         (s_tdata[1:0]),
		.in_amount     (s_tdata[33:2]),
		.in_free_start (s_tdata[65:34]),
		.res_granted   (res_granted),
		.res_offset    (res_offset)
	);

	assign m_tdata = OUT_W'({res_offset, res_granted});

endmodule

`default_nettype wire

>>> dv/ffba_checker.sv
// request/result checker for first_fit_block_allocator_unit: keeps its own block table,
// predicts one result per accepted request and compares it with the result channel
// depends on ffba_pkg for the request codes, table size and offset type
`timescale 1ns / 100ps

module ffba_checker
	import ffba_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic             cfg_we,
	input  wire logic [31:0]      cfg_wdata,
	output int                    errors,
	output int                    n_pending,
	output int                    allocs_granted,
	output int                    allocs_refused
);

	typedef struct packed {
		logic granted;
		ofs_t offset;
	} grant_t;

	ofs_t   region_bytes;
	ofs_t   blk_start [TABLE_ENTRIES];
	ofs_t   blk_len   [TABLE_ENTRIES];
	logic   blk_used  [TABLE_ENTRIES];
	grant_t owed_grants [$];
	grant_t want;

	initial begin
		errors = 0;
		allocs_granted = 0;
		allocs_refused = 0;
	end

	// applies one request to the table copy and returns the result it must produce
	function automatic grant_t serve_request(input logic [1:0] op, input logic [31:0] amt,
			input ofs_t from);
		grant_t r;
		ofs_t   old_len;
		ofs_t   base;
		bit     hit;
		bit     placed;
		r = '0;
		hit = 0;
		placed = 0;
		case (op)
			OP_ALLOC: begin
				for (int i = 0; i < TABLE_ENTRIES && !hit; i++) begin
					if (!blk_used[i] && blk_len[i] >= amt) begin
						hit = 1;
						old_len = blk_len[i];
						base = blk_start[i];
						blk_len[i] = amt;
						blk_used[i] = 1'b1;
						// remainder into the first empty entry, dropped if none
						for (int j = 0; j < TABLE_ENTRIES && !placed; j++) begin
							if (blk_len[j] == '0) begin
								placed = 1;
								blk_start[j] = base + amt;
								blk_len[j] = old_len - amt;
								blk_used[j] = 1'b0;
							end
						end
						r.granted = 1'b1;
						r.offset = base;
					end
				end
				if (hit)
					allocs_granted++;
				else
					allocs_refused++;
			end
			OP_FREE: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (blk_start[i] == from)
						blk_used[i] = 1'b0;
				r.granted = 1'b1;
			end
			OP_FORMAT: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					blk_start[i] = '0;
					blk_len[i] = '0;
					blk_used[i] = 1'b0;
				end
				blk_len[0] = region_bytes;
				r.granted = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_bytes = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				blk_start[i] = '0;
				blk_len[i] = '0;
				blk_used[i] = 1'b0;
			end
			owed_grants.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_grants.size() == 0) begin
					$display("%0t: unexpected result granted=%0b offset=0x%08h",
						$time, m_tdata[0], m_tdata[32:1]);
					errors++;
				end else begin
					want = owed_grants.pop_front();
					if (m_tdata[0] !== want.granted) begin
						$display("%0t: granted expected %0b actual %0b",
							$time, want.granted, m_tdata[0]);
						errors++;
					end
					if (m_tdata[32:1] !== want.offset) begin
						$display("%0t: block_offset expected 0x%08h actual 0x%08h",
							$time, want.offset, m_tdata[32:1]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				owed_grants.push_back(serve_request(s_tdata[1:0], s_tdata[33:2],
					s_tdata[65:34]));
			// region size only takes effect at the next format
			if (cfg_we)
				region_bytes = cfg_wdata;
		end
		n_pending = owed_grants.size();
	end

endmodule

>>> dv/tb.sv
// top of the first-fit block allocator testbench: clock, reset, request stimulus,
// result back-pressure and the final verdict
// depends on ffba_pkg, first_fit_block_allocator_unit and ffba_checker
`timescale 1ns / 100ps

module tb;
	import ffba_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         CYCLE_LIMIT  = 1_000_000;
	localparam int         RANDOM_ITEMS = 2000;
	localparam int         SETTLE       = TABLE_ENTRIES + 16;
	localparam int         QUIET_PHASE  = 3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_we    = 1'b0;
	logic [31:0]       cfg_wdata = '0;

	int   errors;
	int   n_pending;
	int   allocs_granted;
	int   allocs_refused;
	int   cycles = 0;
	int   sent = 0;
	int   regions_set = 0;
	int   op_count [4] = '{0, 0, 0, 0};
	bit   quiet = 0;
	ofs_t live_offsets [$];

	first_fit_block_allocator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ffba_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.errors         (errors),
		.n_pending      (n_pending),
		.allocs_granted (allocs_granted),
		.allocs_refused (allocs_refused)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// granted offsets feed later free requests
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tdata[0]) begin
			live_offsets.push_back(m_tdata[32:1]);
			if (live_offsets.size() > 48)
				live_offsets.pop_front();
		end
	end

	// called and returns at a falling edge; valid stays high until the next request or drain
	task automatic send_req(input logic [1:0] op, input logic [31:0] amt, input logic [31:0] fs);
		int gap;
		gap = 0;
		if (!quiet) begin
			if ($urandom_range(0, 99) < 4)
				gap = $urandom_range(20, 90);
			while ($urandom_range(0, 99) < 25)
				gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {{(IN_W-66){1'b0}}, fs, amt, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
		op_count[op]++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (n_pending != 0)
			@(negedge clk);
	endtask

	task automatic set_region(input logic [31:0] sz);
		cfg_wdata <= sz;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		regions_set++;
	endtask

	initial begin
		int          phase;
		int          n;
		int          pick;
		int          k;
		logic [31:0] sz;
		logic [31:0] amt;
		logic [31:0] fs;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table straight out of reset
		send_req(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send_req(OP_ALLOC, 32'd1, 32'd0);
		send_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// whole 32-bit region, exact fit and zero-amount cases
		drain();
		set_region(32'hFFFF_FFFF);
		send_req(OP_FORMAT, 32'd0, 32'd0);
		send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_req(OP_ALLOC, 32'd1, 32'd0);
		send_req(OP_ALLOC, 32'd0, 32'd0);
		send_req(OP_FREE, 32'd0, 32'd0);
		send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_req(OP_FREE, 32'd0, 32'hFFFF_FFFF);
		send_req(OP_FREE, 32'd0, 32'h1234_5678);

		// small region, split and reuse after free
		drain();
		set_region(32'd1000);
		send_req(OP_FORMAT, 32'd0, 32'd0);
		send_req(OP_ALLOC, 32'd100, 32'd0);
		send_req(OP_ALLOC, 32'd200, 32'd0);
		send_req(OP_ALLOC, 32'd700, 32'd0);
		send_req(OP_ALLOC, 32'd1, 32'd0);
		send_req(OP_FREE, 32'd0, 32'd100);
		send_req(OP_ALLOC, 32'd50, 32'd0);
		send_req(OP_ALLOC, 32'd150, 32'd0);
		send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);

		drain();
		set_region(32'd0);
		send_req(OP_FORMAT, 32'd0, 32'd0);
		send_req(OP_ALLOC, 32'd0, 32'd0);
		send_req(OP_ALLOC, 32'd1, 32'd0);

		n = sent + RANDOM_ITEMS;
		phase = 0;
		while (sent < n) begin
			// every phase starts with the block idle and all results back
			drain();
			quiet = (phase == QUIET_PHASE);
			case ($urandom_range(0, 9))
				0:       sz = 32'd0;
				1:       sz = 32'hFFFF_FFFF;
				2:       sz = $urandom_range(1, 16);
				3, 4, 5: sz = $urandom_range(64, 4096);
				6, 7:    sz = $urandom_range(4097, 1 << 20);
				default: sz = $urandom();
			endcase
			set_region(sz);
			if ($urandom_range(0, 9) != 0)
				send_req(OP_FORMAT, $urandom(), $urandom());
			k = quiet ? 300 : $urandom_range(20, 150);
			repeat (k) begin
				pick = $urandom_range(0, 99);
				amt = $urandom();
				fs = $urandom();
				if (pick < 55) begin
					case ($urandom_range(0, 9))
						0:       amt = 32'd0;
						1:       amt = $urandom();
						2, 3:    amt = $urandom_range(1, 64);
						4:       amt = sz;
						default: amt = (sz >> $urandom_range(2, 7)) + $urandom_range(0, 3);
					endcase
					send_req(OP_ALLOC, amt, fs);
				end else if (pick < 88) begin
					if (live_offsets.size() != 0 && $urandom_range(0, 4) != 0) begin
						k = $urandom_range(0, live_offsets.size() - 1);
						fs = live_offsets[k];
						live_offsets.delete(k);
					end
					send_req(OP_FREE, amt, fs);
				end else if (pick < 95) begin
					send_req(OP_FORMAT, amt, fs);
				end else begin
					send_req(OP_UNUSED, amt, fs);
				end
			end
			quiet = 0;
			phase++;
		end

		drain();
		repeat (SETTLE) @(negedge clk);

		$display("%0d requests: %0d allocate (%0d granted, %0d refused), %0d free, %0d format, %0d unused code",
			sent, op_count[OP_ALLOC], allocs_granted, allocs_refused, op_count[OP_FREE],
			op_count[OP_FORMAT], op_count[OP_UNUSED]);
		$display("%0d region sizes written over %0d random phases, zero and all-ones included",
			regions_set, phase);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> first_fit_block_allocator_unit.f
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator_unit.sv
dv/ffba_checker.sv
dv/tb.sv
